FILE: design/lidar_packet_decoder_top_defines.svh
// Assertion macros shared by the rangefinder packet decoder.
`ifndef LIDAR_PACKET_DECODER_TOP_DEFINES_SVH
`define LIDAR_PACKET_DECODER_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define LPD_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);
// Implication with the consequent checked in the next cycle.
`define LPD_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);
`endif

FILE: design/lpd_pkg.sv
// Types and constants of the rangefinder packet decoder.
package lpd_pkg;
    localparam int MaxSamples = 255;
    localparam logic [7:0] HdrSync   = 8'hA5;
    localparam logic [7:0] HdrNormal = 8'h5A;
    localparam logic [7:0] HdrStart  = 8'h6A;
    localparam logic [17:0] CompNum  = 18'd134369;
    localparam logic [16:0] TurnDone = 17'd35900;

    typedef enum logic [1:0] {
        REG_RES = 2'd0,
        REG_PTS = 2'd1,
        REG_CNT = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        EV_SAMPLE   = 2'd0,
        EV_BAD_HDR  = 2'd1,
        EV_MISMATCH = 2'd2
    } t_event;

    typedef enum logic [1:0] {
        PH_HUNT1  = 2'd0,
        PH_HUNT2  = 2'd1,
        PH_LOCKED = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_DIV1 = 3'd1,
        ST_DIV2 = 3'd2,
        ST_MOD  = 3'd3,
        ST_OUT  = 3'd4
    } t_state;
endpackage

FILE: design/lidar_packet_decoder_top.sv
// Rangefinder serial packet decoder: sync hunt, header checks, sample decode.
// Header bytes are absorbed one per accepted beat. The third byte of a sample
// starts a sequence on one shared restoring divider: first the range
// compensation quotient, then the angle over the resolution (rounded from
// the remainder), then the signed beam slot modulo the beam count. The end
// of the modulo step loads the output register and the output state then
// raises valid. Fault events are presented the cycle after
// the packet's last beat. Input is not ready while the divider runs or while
// a sample or event waits in the output register.
`include "lidar_packet_decoder_top_defines.svh"
module lidar_packet_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] serial_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [1:0] event_res, [17:2] beam_index,
                                        // [25:18] intensity, [41:26] range_mm,
                                        // [42] scan_start, [43] scan_complete, pad
    output logic        m_axis_tlast,   // last_of_packet
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import lpd_pkg::*;

    logic [6:0]  r_res;
    logic [7:0]  r_pts;
    logic [15:0] r_cnt;
    t_phase      r_phase;
    logic [9:0]  r_pos;
    logic [1:0]  r_k;
    logic [16:0] r_angle;
    logic [7:0]  r_sample;
    logic [7:0]  r_hint, r_hrh;
    logic [1:0]  r_fault;
    logic        r_start;
    t_state      r_state, n_state;

    // divider registers
    logic [18:0] r_rem;
    logic [17:0] r_quo;
    logic [17:0] r_dvs;
    logic [4:0]  r_cyc;
    logic        r_neg;
    logic [15:0] r_range;
    logic [7:0]  r_oint;
    logic        r_ostart, r_ocomp, r_olast;

    logic        r_ovalid;
    logic [1:0]  r_oev;
    logic [15:0] r_obeam;

    assign o_cfg_ready = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {4'd0, r_ocomp, r_ostart, r_range, r_oint, r_obeam, r_oev};

    logic        acc;
    logic [7:0]  b;
    logic [7:0]  pts_c;
    logic [9:0]  last_pos;
    logic        is_end;
    logic [1:0]  k;
    logic [16:0] ang_next;
    assign acc = s_axis_tvalid && s_axis_tready;
    assign b = s_axis_tdata;
    assign pts_c = r_pts;   // width 8 already limits to MaxSamples
    assign last_pos = 10'd5 + 10'd3 * {2'd0, pts_c};
    assign is_end = (r_pos >= 10'd5) && (r_pos >= last_pos);
    assign k = r_k;
    assign ang_next = r_angle + {10'd0, r_res};

    // one restoring division step
    logic [18:0] trial;
    assign trial = {r_rem[17:0], r_quo[17]} - {1'b0, r_dvs};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (acc && r_phase == PH_LOCKED && r_pos >= 10'd6 && k == 2'd2
                         && r_fault == 2'd0) n_state = ST_DIV1;
            ST_DIV1: if (r_cyc == 5'd17) n_state = ST_DIV2;
            ST_DIV2: if (r_cyc == 5'd17) n_state = ST_MOD;
            ST_MOD:  if (r_cyc == 5'd17) n_state = ST_OUT;
            ST_OUT:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= 7'd25; r_pts <= 8'd60; r_cnt <= 16'd1440;
            r_phase <= PH_HUNT1; r_pos <= '0; r_k <= '0; r_angle <= '0; r_sample <= '0;
            r_hint <= '0; r_hrh <= '0; r_fault <= '0; r_start <= 1'b0;
            r_state <= ST_IDLE; r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            if (i_cfg_valid) begin
                unique case (t_reg_idx'(i_cfg_index))
                    REG_RES: r_res <= i_cfg_data[6:0];
                    REG_PTS: r_pts <= i_cfg_data[7:0];
                    REG_CNT: r_cnt <= i_cfg_data;
                    default: ;
                endcase
            end
            if (acc) begin
                priority if (r_phase == PH_HUNT1) begin
                    if (b == HdrSync) r_phase <= PH_HUNT2;
                end else if (r_phase == PH_HUNT2) begin
                    if (b == HdrNormal || b == HdrStart) begin
                        r_phase <= PH_LOCKED; r_pos <= 10'd2; r_fault <= '0;
                        r_sample <= '0; r_start <= (b == HdrStart);
                    end else r_phase <= PH_HUNT1;
                end else begin
                    logic [1:0] f;
                    f = r_fault;
                    unique case (r_pos)
                        10'd0: begin
                            f = (b != HdrSync) ? EV_BAD_HDR : 2'd0;
                            r_start <= 1'b0; r_sample <= '0;
                        end
                        10'd1: begin
                            if (b == HdrStart) r_start <= 1'b1;
                            else if (b != HdrNormal && f == 2'd0) f = EV_BAD_HDR;
                        end
                        10'd2: if (!b[7] && f == 2'd0) f = EV_MISMATCH;
                        10'd3: ;
                        10'd4: begin
                            if (b[7:1] != r_res && f == 2'd0) f = EV_MISMATCH;
                            r_angle <= {16'd0, b[0]};
                        end
                        10'd5: begin
                            r_angle <= 17'({r_angle[0], b} * 17'd100);
                            r_k <= 2'd0;
                        end
                        default: begin
                            r_k <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                            if (k == 2'd0) r_hint <= b;
                            else if (k == 2'd1) r_hrh <= b;
                            else if (f == 2'd0) begin
                                // launch the compensation divide
                                r_range <= {r_hrh, b};
                                r_oint <= r_hint;
                                r_olast <= (r_pos >= last_pos);
                                r_rem <= '0;
                                r_quo <= CompNum + {3'd0, r_hrh, b[7:1]};
                                r_dvs <= {2'd0, r_hrh, b};
                                r_cyc <= '0;
                            end
                        end
                    endcase
                    r_fault <= f;
                    if (is_end) begin
                        if (f != 2'd0) begin
                            r_ovalid <= 1'b1; r_oev <= f; r_obeam <= '0;
                            r_range <= '0; r_oint <= '0; r_ostart <= 1'b0;
                            r_ocomp <= 1'b0; r_olast <= 1'b0; r_phase <= PH_HUNT1;
                        end
                        r_pos <= '0; r_fault <= '0;
                    end else r_pos <= r_pos + 10'd1;
                end
            end
            unique case (r_state)
                ST_DIV1, ST_DIV2, ST_MOD: begin
                    if (trial[18]) begin
                        r_rem <= {r_rem[17:0], r_quo[17]};
                        r_quo <= {r_quo[16:0], 1'b0};
                    end else begin
                        r_rem <= trial;
                        r_quo <= {r_quo[16:0], 1'b1};
                    end
                    r_cyc <= r_cyc + 5'd1;
                end
                default: ;
            endcase
            if (r_state == ST_DIV1 && r_cyc == 5'd17) begin
                logic [17:0] off;
                logic signed [19:0] ca;
                logic [18:0] mg;
                off = (r_range == 16'd0) ? 18'd0
                    : (trial[18] ? {r_quo[16:0], 1'b0} : {r_quo[16:0], 1'b1});
                ca = $signed({3'd0, r_angle}) - $signed({2'd0, off});
                mg = ca[19] ? 19'(-ca) : ca[18:0];
                r_neg <= ca[19];
                r_rem <= '0; r_cyc <= '0;
                r_quo <= mg[17:0];
                r_dvs <= {11'd0, r_res};
            end
            if (r_state == ST_DIV2 && r_cyc == 5'd17) begin
                logic [17:0] q;
                logic [17:0] rm;
                logic        up;
                logic signed [19:0] qs;
                logic signed [19:0] sl;
                // round half away from zero from the remainder
                rm = trial[18] ? {r_rem[16:0], r_quo[17]} : trial[17:0];
                up = ({rm, 1'b0} >= {12'd0, r_res});
                q = (r_res == 7'd0) ? 18'd0
                  : (trial[18] ? {r_quo[16:0], 1'b0} : {r_quo[16:0], 1'b1}) + {17'd0, up};
                qs = r_neg ? -$signed({2'd0, q}) : $signed({2'd0, q});
                sl = (qs < 0) ? -qs : $signed({4'd0, r_cnt}) - qs;
                r_neg <= sl[19];
                r_rem <= '0; r_cyc <= '0;
                r_quo <= sl[19] ? 18'(-sl) : sl[17:0];
                r_dvs <= {2'd0, r_cnt};
            end
            if (r_state == ST_MOD && n_state == ST_OUT) begin
                logic [17:0] rmd;
                rmd = trial[18] ? {r_rem[16:0], r_quo[17]} : trial[17:0];
                if (r_cnt == 16'd0) r_obeam <= 16'd0;
                else if (r_neg && rmd != 18'd0) r_obeam <= r_cnt - rmd[15:0];
                else r_obeam <= rmd[15:0];
                r_oev <= EV_SAMPLE;
                r_ostart <= r_start; r_start <= 1'b0;
                r_angle <= ang_next;
                r_ocomp <= r_olast && (ang_next >= TurnDone);
                if (r_sample != 8'd255) r_sample <= r_sample + 8'd1;
            end
            if (r_state == ST_OUT) r_ovalid <= 1'b1;
        end
    end

    `LPD_ASSERT_IMP(a_busy_not_ready, i_clk, i_rst_n, r_state != ST_IDLE, !s_axis_tready, "ready while busy")
    `LPD_ASSERT_NEXT(a_out_valid, i_clk, i_rst_n, r_state == ST_OUT, m_axis_tvalid, "result lost")
    `LPD_ASSERT_IMP(a_fault_code, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[1:0] != EV_SAMPLE, !m_axis_tlast, "fault with tlast")
endmodule

FILE: tb/lidar_packet_decoder_top_tb.sv
// Self-checking testbench for the rangefinder packet decoder: packet streams in, checked samples and fault events out.
`timescale 1ns / 1ps
module lidar_packet_decoder_top_tb;
    import lpd_pkg::*;

    typedef struct packed {
        t_event      ev;
        logic [15:0] beam;
        logic [7:0]  inten;
        logic [15:0] range;
        logic        scan_start;
        logic        scan_done;
        logic        last;
    } t_beat;

    class lidar_scoreboard;
        logic [6:0]  res_cfg;
        logic [7:0]  pts_cfg;
        logic [15:0] cnt_cfg;
        t_phase      phase;
        int unsigned pos, angle, nsample;
        logic [7:0]  hold_inten, hold_rhi;
        t_event      fault;
        logic        start_flag;
        t_beat       expected_q[$];
        int          errors;

        function new();
            res_cfg = 7'd25; pts_cfg = 8'd60; cnt_cfg = 16'd1440;
            phase = PH_HUNT1; pos = 0; angle = 0; nsample = 0;
            hold_inten = 0; hold_rhi = 0; fault = EV_SAMPLE; start_flag = 0;
            errors = 0;
        endfunction

        function void write_reg(t_reg_idx idx, logic [15:0] val);
            case (idx)
                REG_RES: res_cfg = val[6:0];
                REG_PTS: pts_cfg = val[7:0];
                REG_CNT: cnt_cfg = val;
                default: ;
            endcase
        endfunction

        function void flag_fault(t_event code);
            if (fault == EV_SAMPLE) fault = code;
        endfunction

        function logic [15:0] beam_slot(int unsigned range);
            longint ang, res, cnt, q, mag, slot;
            ang = angle; res = res_cfg; cnt = cnt_cfg; q = 0;
            if (range != 0) ang -= (134369 + range / 2) / range;
            if (res != 0) begin
                mag = ang < 0 ? -ang : ang;
                q = (2 * mag + res) / (2 * res);
                if (ang < 0) q = -q;
            end
            slot = (q < 0) ? -q : cnt - q;
            if (cnt == 0) return 16'd0;
            slot = slot % cnt;
            if (slot < 0) slot += cnt;
            return slot[15:0];
        endfunction

        // Advance the decoder by one accepted byte.
        function void note_byte(logic [7:0] b);
            int unsigned pts, last_pos, k, range;
            t_beat r;
            bit has;
            pts = pts_cfg > MaxSamples ? MaxSamples : pts_cfg;
            last_pos = 5 + 3 * pts;
            has = 0;
            r = '0;
            if (phase == PH_HUNT1) begin
                if (b == HdrSync) phase = PH_HUNT2;
                return;
            end
            if (phase != PH_LOCKED) begin
                if (b == HdrNormal || b == HdrStart) begin
                    phase = PH_LOCKED; pos = 2; fault = EV_SAMPLE; nsample = 0;
                    start_flag = (b == HdrStart);
                end else begin
                    phase = PH_HUNT1;
                end
                return;
            end
            case (pos)
                0: begin
                    fault = EV_SAMPLE; start_flag = 0; nsample = 0;
                    if (b != HdrSync) flag_fault(EV_BAD_HDR);
                end
                1: begin
                    if (b == HdrStart) start_flag = 1;
                    else if (b != HdrNormal) flag_fault(EV_BAD_HDR);
                end
                2: if (!b[7]) flag_fault(EV_MISMATCH);
                3: ;
                4: begin
                    if (b[7:1] != res_cfg) flag_fault(EV_MISMATCH);
                    angle = b[0];
                end
                5: angle = ((((angle & 1) << 8) | b) * 100) & 'h1FFFF;
                default: begin
                    k = (pos - 6) % 3;
                    if (k == 0) hold_inten = b;
                    else if (k == 1) hold_rhi = b;
                    else if (fault == EV_SAMPLE) begin
                        range = {hold_rhi, b};
                        r.ev = EV_SAMPLE;
                        r.beam = beam_slot(range);
                        r.inten = hold_inten;
                        r.range = range[15:0];
                        r.scan_start = start_flag;
                        angle = (angle + res_cfg) & 'h1FFFF;
                        r.last = pos >= last_pos;
                        r.scan_done = r.last && angle >= TurnDone;
                        start_flag = 0;
                        if (nsample < 255) nsample++;
                        has = 1;
                    end
                end
            endcase
            if (pos >= 5 && pos >= last_pos) begin
                if (fault != EV_SAMPLE) begin
                    r = '0;
                    r.ev = fault;
                    has = 1;
                    phase = PH_HUNT1;
                end
                pos = 0; start_flag = 0; nsample = 0; fault = EV_SAMPLE;
            end else begin
                pos = (pos + 1) & 'h3FF;
            end
            if (has) expected_q.push_back(r);
        endfunction

        function void check(t_beat got);
            t_beat want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual %p", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.ev != want.ev) report("event", want.ev, got.ev);
            if (got.beam != want.beam) report("beam_index", want.beam, got.beam);
            if (got.inten != want.inten) report("intensity", want.inten, got.inten);
            if (got.range != want.range) report("range_mm", want.range, got.range);
            if (got.scan_start != want.scan_start)
                report("scan_start", want.scan_start, got.scan_start);
            if (got.scan_done != want.scan_done)
                report("scan_complete", want.scan_done, got.scan_done);
            if (got.last != want.last) report("last", want.last, got.last);
        endfunction

        function void report(string what, int unsigned exp_v, int unsigned act_v);
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
            errors++;
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = REG_RES;
    logic [15:0] i_cfg_data = 0;

    lidar_scoreboard sb = new();
    bit quiet = 0;
    int unsigned bytes_sent = 0;
    int unsigned stall_left = 0;

    always #6 i_clk = ~i_clk;

    lidar_packet_decoder_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Receiver: random stall bursts, none in the closing stretch.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= (stall_left == 1);
        end else if (!quiet && i_rst_n && $urandom_range(0, 11) == 0) begin
            stall_left <= $urandom_range(1, 18);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_beat got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.ev = t_event'(m_axis_tdata[1:0]);
            got.beam = m_axis_tdata[17:2];
            got.inten = m_axis_tdata[25:18];
            got.range = m_axis_tdata[41:26];
            got.scan_start = m_axis_tdata[42];
            got.scan_done = m_axis_tdata[43];
            got.last = m_axis_tlast;
            sb.check(got);
        end
    end

    task automatic put_byte(input logic [7:0] b);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_range();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'($urandom_range(1, 8));
            2: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // kind: 0 good, 1 bad sync, 2 bad second byte, 3 intensity bit clear,
    // 4 resolution mismatch
    task automatic send_packet(input int kind, input bit start, input bit near_turn);
        logic [8:0] deg;
        logic [6:0] res;
        deg = near_turn ? 9'($urandom_range(340, 511)) : 9'($urandom);
        res = sb.res_cfg;
        if (kind == 4) res = res ^ 7'($urandom_range(1, 127));
        put_byte(kind == 1 ? 8'($urandom_range(0, 164)) : HdrSync);
        put_byte(kind == 2 ? 8'h00 : (start ? HdrStart : HdrNormal));
        put_byte({kind != 3, 7'($urandom)});
        put_byte(8'($urandom));
        put_byte({res, deg[8]});
        put_byte(deg[7:0]);
        repeat (sb.pts_cfg) begin
            logic [15:0] rng;
            rng = pick_range();
            put_byte(8'($urandom));
            put_byte(rng[15:8]);
            put_byte(rng[7:0]);
        end
    endtask

    task automatic send_random(input int unsigned budget);
        int unsigned stop_at;
        int sel;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at) begin
            sel = $urandom_range(0, 19);
            if (sel < 14) send_packet(0, $urandom_range(0, 1), $urandom_range(0, 2) == 0);
            else if (sel < 18) send_packet($urandom_range(1, 4), $urandom_range(0, 1), 0);
            else if (sel == 18) begin
                put_byte(HdrSync); put_byte(HdrSync); put_byte(HdrNormal);
            end else begin
                repeat ($urandom_range(1, 6)) put_byte(8'($urandom));
            end
        end
    endtask

    initial begin
        #(12 * 800000);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        logic [6:0]  res_set[6] = '{7'd25, 7'd1, 7'd127, 7'd7, 7'd64, 7'd13};
        logic [7:0]  pts_set[6] = '{8'd2, 8'd1, 8'd3, 8'd255, 8'd5, 8'd4};
        logic [15:0] cnt_set[6] = '{16'd1440, 16'd1, 16'd36000, 16'd360, 16'd720, 16'd1000};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed: short packets, start header, turn end, ranges 0 and max, faults.
        write_reg(REG_PTS, 16'd1);
        put_byte(HdrSync); put_byte(HdrStart); put_byte(8'h80); put_byte(8'h00);
        put_byte({7'd25, 1'b1}); put_byte(8'd103);
        put_byte(8'hFF); put_byte(8'h00); put_byte(8'h00);
        put_byte(HdrSync); put_byte(HdrNormal); put_byte(8'hFF); put_byte(8'hFF);
        put_byte({7'd25, 1'b0}); put_byte(8'h00);
        put_byte(8'h00); put_byte(8'hFF); put_byte(8'hFF);
        send_packet(3, 0, 0);
        put_byte(HdrSync); put_byte(HdrSync); put_byte(HdrNormal);
        send_packet(4, 1, 0);
        send_packet(0, 0, 0);
        send_packet(1, 0, 0);
        drain();

        for (int p = 0; p < 6; p++) begin
            write_reg(REG_RES, 16'(res_set[p]));
            write_reg(REG_PTS, 16'(pts_set[p]));
            write_reg(REG_CNT, cnt_set[p]);
            if (p == 5) quiet = 1;
            send_random(p == 3 ? 100 : 150);
            drain();
        end

        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
